// ===== rtl/cmrg_pkg.sv =====
// Types, constants and modular arithmetic helpers for the combined MRG uniform generator.
package cmrg_pkg;

    typedef logic [31:0] t_word;
    typedef logic [20:0] t_mult;
    typedef logic [15:0] t_gap;
    typedef logic [2:0]  t_cfg_idx;

    // Moduli of the two components and their distance below 2^32.
    localparam t_word MOD_A = 32'd4294967087;
    localparam t_word MOD_B = 32'd4294944443;
    localparam t_gap  GAP_A = 16'd209;
    localparam t_gap  GAP_B = 16'd22853;

    // Recurrence multipliers.
    localparam t_mult MUL_A1 = 21'd1403580;
    localparam t_mult MUL_A0 = 21'd810728;
    localparam t_mult MUL_B2 = 21'd527612;
    localparam t_mult MUL_B0 = 21'd1370589;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_SEED_A0 = 3'd0;
    localparam t_cfg_idx CFG_SEED_A1 = 3'd1;
    localparam t_cfg_idx CFG_SEED_A2 = 3'd2;
    localparam t_cfg_idx CFG_SEED_B0 = 3'd3;
    localparam t_cfg_idx CFG_SEED_B1 = 3'd4;
    localparam t_cfg_idx CFG_SEED_B2 = 3'd5;

    // (c * x) mod m for m = 2^32 - gap. The high part of the product is folded
    // back as high * gap three times, which leaves a value below 2m.
    function automatic t_word mul_mod(input t_mult c, input t_word x,
                                      input t_gap gap, input t_word m);
        logic [52:0] prod;
        logic [37:0] fold1;
        logic [32:0] fold2;
        logic [32:0] fold3;
        prod  = 53'(c) * 53'(x);
        fold1 = 38'(prod[52:32]) * 38'(gap) + 38'(prod[31:0]);
        fold2 = 33'(fold1[37:32]) * 33'(gap) + 33'(fold1[31:0]);
        fold3 = (fold2[32] ? 33'(gap) : 33'd0) + 33'(fold2[31:0]);
        return (fold3[31:0] >= m) ? (fold3[31:0] - m) : fold3[31:0];
    endfunction

    // (pos - neg) mod m for pos and neg already in 0..m-1.
    function automatic t_word sub_mod(input t_word pos, input t_word neg, input t_word m);
        return (pos >= neg) ? (pos - neg) : (pos + (m - neg));
    endfunction

endpackage

// ===== rtl/combined_mrg_uniform_generator.sv =====
// Top level of the combined MRG uniform generator with seed registers and output register.

// One sample leaves per accepted request, and a request can be accepted in every cycle
// while the output register is empty or being drained: the sample appears on the output
// register in the cycle after acceptance. Both order-3 recurrences, their constant
// multiplications with modular folding, and the final combination are done
// combinationally from the history registers, so the newest words of both components are
// ready for the next request. The input stays ready while the output register is empty
// or being drained. Configuration writes are taken in every cycle; an index beyond five
// is ignored. When restart is set, both histories are reloaded from the seed registers before the draw.
module combined_mrg_uniform_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_restart,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cmrg_pkg::t_word     o_sample,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  cmrg_pkg::t_cfg_idx  i_cfg_index,
    input  cmrg_pkg::t_word     i_cfg_data
);
    import cmrg_pkg::*;

    t_word r_seed_a [3];
    t_word r_seed_b [3];
    t_word r_ha     [3];
    t_word r_hb     [3];
    t_word n_ha     [3];
    t_word n_hb     [3];
    t_word src_a    [3];
    t_word src_b    [3];
    t_word new_a;
    t_word new_b;
    t_word n_sample;
    t_word r_sample;
    logic  r_out_valid;
    logic  in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // Draw logic: pick seeds or history, advance both components, combine.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            src_a[k] = i_restart ? r_seed_a[k] : r_ha[k];
            src_b[k] = i_restart ? r_seed_b[k] : r_hb[k];
        end
        new_a = sub_mod(mul_mod(MUL_A1, src_a[1], GAP_A, MOD_A),
                        mul_mod(MUL_A0, src_a[0], GAP_A, MOD_A), MOD_A);
        new_b = sub_mod(mul_mod(MUL_B2, src_b[2], GAP_B, MOD_B),
                        mul_mod(MUL_B0, src_b[0], GAP_B, MOD_B), MOD_B);
        // Equal or smaller first component wraps up by MOD_A, so the sample is never zero.
        n_sample = (new_a > new_b) ? (new_a - new_b) : (new_a + (MOD_A - new_b));
        n_ha[0] = src_a[1];
        n_ha[1] = src_a[2];
        n_ha[2] = new_a;
        n_hb[0] = src_b[1];
        n_hb[1] = src_b[2];
        n_hb[2] = new_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_a[0] <= '0;
            r_seed_a[1] <= '0;
            r_seed_a[2] <= 32'd1;
            r_seed_b[0] <= '0;
            r_seed_b[1] <= '0;
            r_seed_b[2] <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED_A0: r_seed_a[0] <= i_cfg_data;
                CFG_SEED_A1: r_seed_a[1] <= i_cfg_data;
                CFG_SEED_A2: r_seed_a[2] <= i_cfg_data;
                CFG_SEED_B0: r_seed_b[0] <= i_cfg_data;
                CFG_SEED_B1: r_seed_b[1] <= i_cfg_data;
                CFG_SEED_B2: r_seed_b[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ha[0]     <= '0;
            r_ha[1]     <= '0;
            r_ha[2]     <= 32'd1;
            r_hb[0]     <= '0;
            r_hb[1]     <= '0;
            r_hb[2]     <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ha        <= n_ha;
                r_hb        <= n_hb;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= n_sample;
        end
    end

    // A shown sample always lies in 1..MOD_A.
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != '0 && o_sample <= MOD_A))
        else $error("sample outside 1..MOD_A");

    // Every accepted request leaves a sample in the output register.
    a_acc_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted request produced no sample");

    // Newly computed history words are fully reduced.
    a_new_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_ha[2] < MOD_A && r_hb[2] < MOD_B))
        else $error("new history word not reduced");

    // A restart shifts the seeds into the history.
    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_restart) |=> (r_ha[0] == $past(r_seed_a[1])
                                   && r_hb[1] == $past(r_seed_b[2])))
        else $error("restart did not reload history from seeds");

endmodule

// ===== tb/cmrg_checker.sv =====
// Checker for the combined MRG uniform generator: predicts each sample and compares it.
`timescale 1ns / 100ps

module cmrg_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_restart,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cmrg_pkg::t_word     i_sample,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  cmrg_pkg::t_cfg_idx  i_cfg_index,
    input  cmrg_pkg::t_word     i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import cmrg_pkg::*;

    t_word seed_a [3];
    t_word seed_b [3];
    t_word hist_a [3];
    t_word hist_b [3];
    t_word samples_due [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Exact (c_pos * x_pos - c_neg * x_neg) mod m, done in 64 bits.
    function automatic t_word mod_recur(input t_mult c_pos, input t_word x_pos,
                                        input t_mult c_neg, input t_word x_neg,
                                        input t_word m);
        bit [63:0] pos;
        bit [63:0] neg;
        pos = (64'(c_pos) * 64'(x_pos)) % 64'(m);
        neg = (64'(c_neg) * 64'(x_neg)) % 64'(m);
        return t_word'((pos >= neg) ? (pos - neg) : (pos + 64'(m) - neg));
    endfunction

    // Advances both recurrences by one step and returns the combined sample.
    function automatic t_word next_sample(input logic restart);
        t_word na;
        t_word nb;
        if (restart) begin
            for (int i = 0; i < 3; i++) begin
                hist_a[i] = seed_a[i];
                hist_b[i] = seed_b[i];
            end
        end
        na = mod_recur(MUL_A1, hist_a[1], MUL_A0, hist_a[0], MOD_A);
        nb = mod_recur(MUL_B2, hist_b[2], MUL_B0, hist_b[0], MOD_B);
        hist_a[0] = hist_a[1];
        hist_a[1] = hist_a[2];
        hist_a[2] = na;
        hist_b[0] = hist_b[1];
        hist_b[1] = hist_b[2];
        hist_b[2] = nb;
        if (na > nb) begin
            return na - nb;
        end
        return t_word'(64'(na) + 64'(MOD_A) - 64'(nb));
    endfunction

    always @(posedge i_clk) begin : watch
        t_word want;
        if (!i_rst_n) begin
            seed_a = '{32'd0, 32'd0, 32'd1};
            seed_b = '{32'd0, 32'd0, 32'd1};
            hist_a = '{32'd0, 32'd0, 32'd1};
            hist_b = '{32'd0, 32'd0, 32'd1};
            samples_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: unexpected sample: expected none, got %0d", $time, i_sample);
                    o_errors = o_errors + 1;
                end else begin
                    want = samples_due.pop_front();
                    if (want !== i_sample) begin
                        $display("%0t: sample mismatch: expected %0d, got %0d",
                                 $time, want, i_sample);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index <= CFG_SEED_A2) begin
                    seed_a[i_cfg_index] = i_cfg_data;
                end else if (i_cfg_index <= CFG_SEED_B2) begin
                    seed_b[i_cfg_index - CFG_SEED_B0] = i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                samples_due.push_back(next_sample(i_restart));
            end
        end
        o_pending = samples_due.size();
    end

endmodule

// ===== tb/combined_mrg_uniform_generator_tb.sv =====
// Testbench top for the combined MRG uniform generator: stimulus, idling and verdict.
`timescale 1ns / 100ps

module combined_mrg_uniform_generator_tb;
    import cmrg_pkg::*;

    // Indexes past the last seed register; writes to them must be dropped.
    localparam t_cfg_idx CFG_UNUSED_LO = 3'd6;
    localparam t_cfg_idx CFG_UNUSED_HI = 3'd7;

    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 120;
    localparam int HOLD_LONG  = 80;
    localparam int PRESS_PHASE = 6;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    logic     restart;
    logic     out_valid;
    logic     out_ready;
    t_word    sample;
    logic     cfg_valid;
    logic     cfg_ready;
    t_cfg_idx cfg_index;
    t_word    cfg_data;
    int       errors;
    int       pending;
    bit       no_idle;
    int       holds_asked;
    int       holds_done;

    combined_mrg_uniform_generator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_restart   (restart),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_sample    (sample),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cmrg_checker checker_0 (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_restart   (restart),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_sample    (sample),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic request_draw(input logic rs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        restart  = rs;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_word val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_seeds(input t_word a0, input t_word a1, input t_word a2,
                               input t_word b0, input t_word b1, input t_word b2);
        write_reg(CFG_SEED_A0, a0);
        write_reg(CFG_SEED_A1, a1);
        write_reg(CFG_SEED_A2, a2);
        write_reg(CFG_SEED_B0, b0);
        write_reg(CFG_SEED_B1, b1);
        write_reg(CFG_SEED_B2, b2);
    endtask

    // Stops requesting and waits until every sample has been taken.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic t_word pick_seed(input t_word m);
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return m - 32'd1;
            3:       return m;
            4:       return t_word'($urandom_range(0, 15));
            default: return t_word'($urandom);
        endcase
    endfunction

    // Receiver: random stalls per sample, plus one long hold when asked.
    initial begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                gap = HOLD_LONG;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        bit rs;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        restart     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SEED_A0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        holds_asked = 0;
        holds_done  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset seeds, first continuing from the reset history, then reloading.
        request_draw(1'b0);
        request_draw(1'b0);
        request_draw(1'b0);
        request_draw(1'b1);
        settle();

        // Both components all zero: every sample equals the first modulus.
        write_seeds(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        request_draw(1'b1);
        request_draw(1'b0);
        request_draw(1'b0);
        settle();

        // Seeds above the moduli pass through the history unreduced.
        write_seeds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        request_draw(1'b1);
        request_draw(1'b0);
        request_draw(1'b0);
        request_draw(1'b0);
        settle();

        write_seeds(MOD_A - 32'd1, MOD_A - 32'd1, MOD_A - 32'd1,
                    MOD_B - 32'd1, MOD_B - 32'd1, MOD_B - 32'd1);
        request_draw(1'b1);
        request_draw(1'b0);
        request_draw(1'b0);
        settle();

        // Only the first component stuck at zero.
        write_seeds(32'd0, 32'd0, 32'd0, 32'd12345, 32'd678, 32'd9);
        request_draw(1'b1);
        request_draw(1'b0);
        settle();

        // Writes past the last register must leave the seeds alone.
        write_reg(CFG_UNUSED_LO, 32'hA5A5_5A5A);
        write_reg(CFG_UNUSED_HI, 32'h5A5A_A5A5);
        request_draw(1'b1);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            no_idle = (ph % 4 == 1);
            write_seeds(pick_seed(MOD_A), pick_seed(MOD_A), pick_seed(MOD_A),
                        pick_seed(MOD_B), pick_seed(MOD_B), pick_seed(MOD_B));
            if ($urandom_range(0, 1) == 1) begin
                write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                          t_word'($urandom));
            end
            if (ph == PRESS_PHASE) begin
                // Sender keeps offering while the receiver holds off.
                no_idle = 1'b1;
                holds_asked = holds_asked + 1;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                rs = (n == 0) ? 1'b1 : ($urandom_range(0, 11) == 0);
                request_draw(rs);
            end
            settle();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
